### sv/mplm_pkg.sv
package mplm_pkg;
    localparam int MAX_MASKS = 16;
    localparam int DIM_BITS  = 12;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 24;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [2:0] K_DESC   = 3'd0;
    localparam logic [2:0] K_AREA   = 3'd1;
    localparam logic [2:0] K_RESOLV = 3'd2;
    localparam logic [2:0] K_LABEL  = 3'd3;
    localparam logic [2:0] K_REPORT = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIM   = 2'd1;
    localparam logic [1:0] ST_NOMSK = 2'd2;
    localparam logic [1:0] ST_PIX   = 2'd3;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_COUNT  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_SORT, S_OUT, S_REPORT
    } t_state;

    typedef struct packed {
        logic        man;
        logic [31:0] pri;
        logic [15:0] stab;
        logic [15:0] iou;
        logic [CNT_W-1:0] area;
        logic [IDX_W-1:0] idx;
    } t_key;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction
endpackage

### sv/mplm_cmp.sv
module mplm_cmp import mplm_pkg::*; (
    input  t_key i_a,
    input  t_key i_b,
    output logic o_before
);
    always_comb begin
        if (i_a.man != i_b.man)
            o_before = i_a.man;
        else if (i_a.man && i_a.pri != i_b.pri)
            o_before = $signed(i_a.pri) < $signed(i_b.pri);
        else if (!i_a.man && i_a.stab != i_b.stab)
            o_before = i_a.stab > i_b.stab;
        else if (!i_a.man && i_a.iou != i_b.iou)
            o_before = i_a.iou > i_b.iou;
        else if (!i_a.man && i_a.area != i_b.area)
            o_before = i_a.area > i_b.area;
        else
            o_before = i_a.idx < i_b.idx;
    end
endmodule

### sv/mask_priority_label_map.sv
// Channel  | Direction | Handshake            | Payload
// input    | in        | i_valid / o_ready    | i_kind .. i_coverage
// result   | out       | o_valid / i_ready    | o_label .. o_last
// config   | in        | i_cfg_we (no wait)   | i_cfg_index, i_cfg_data
// Descriptor and area pixel beats update state; a label pixel beat loads the
// output register, which holds the result until taken.
// Resolve: one shared rank comparator, insertion sort one compare a cycle.
// Report: one beat per mask in use, or one status beat if resolve failed or
// no mask is in use; one per cycle while i_ready is high.
// Reset is synchronous, active low; the input is not ready while a result waits.
module mask_priority_label_map import mplm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [11:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_kind,
    input  logic [3:0]          i_mask_index,
    input  logic                i_manual_set,
    input  logic signed [31:0]  i_manual_priority,
    input  logic [15:0]         i_stability_score,
    input  logic [15:0]         i_predicted_iou,
    input  logic [15:0]         i_coverage,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [4:0]          o_label,
    output logic [3:0]          o_region_index,
    output logic [23:0]         o_region_pixels,
    output logic [1:0]          o_status,
    output logic                o_last
);
    t_state r_state, n_state;
    logic [DIM_BITS-1:0] r_width, r_height;
    logic [4:0] r_count;
    logic [MAX_MASKS-1:0]      r_man;
    logic [31:0]               r_pri  [MAX_MASKS];
    logic [15:0]               r_stab [MAX_MASKS];
    logic [15:0]               r_iou  [MAX_MASKS];
    logic [CNT_W-1:0]          r_area [MAX_MASKS];
    logic [IDX_W-1:0]          r_ord  [MAX_MASKS];
    logic [CNT_W-1:0]          r_reg  [MAX_MASKS];
    logic [CNT_W-1:0]          r_apix;
    logic [1:0]                r_rstat;
    // sort cursors: outer i, inner j (compares ord[j] with ord[j-1])
    logic [4:0]                r_i, r_j;
    logic [4:0]                r_rep;
    logic [4:0]                w_n;
    logic                      w_acc, w_take;
    logic                      w_ov_set;
    t_key                      w_ka, w_kb;
    logic                      w_before;
    logic [4:0]                w_lab;
    logic                      w_hit;

    logic        r_ov;
    logic [4:0]  r_olab;
    logic [3:0]  r_oidx;
    logic [23:0] r_opix;
    logic [1:0]  r_ost;
    logic        r_olast;

    assign w_n    = (r_count > 5'(MAX_MASKS)) ? 5'(MAX_MASKS) : r_count;
    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign w_acc  = i_valid && o_ready;
    assign w_take = r_ov && i_ready;
    // load the output register: label beat, resolve status, or next report beat
    assign w_ov_set = (r_state == S_IDLE && w_acc && i_kind == K_LABEL)
                    || (r_state == S_OUT)
                    || (r_state == S_REPORT && (!r_ov || i_ready));

    // shared comparator on the pair under the inner cursor
    always_comb begin
        w_ka.man  = r_man[r_ord[r_j[3:0]]];
        w_ka.pri  = r_pri[r_ord[r_j[3:0]]];
        w_ka.stab = r_stab[r_ord[r_j[3:0]]];
        w_ka.iou  = r_iou[r_ord[r_j[3:0]]];
        w_ka.area = r_area[r_ord[r_j[3:0]]];
        w_ka.idx  = r_ord[r_j[3:0]];
        w_kb.man  = r_man[r_ord[4'(r_j - 5'd1)]];
        w_kb.pri  = r_pri[r_ord[4'(r_j - 5'd1)]];
        w_kb.stab = r_stab[r_ord[4'(r_j - 5'd1)]];
        w_kb.iou  = r_iou[r_ord[4'(r_j - 5'd1)]];
        w_kb.area = r_area[r_ord[4'(r_j - 5'd1)]];
        w_kb.idx  = r_ord[4'(r_j - 5'd1)];
    end

    mplm_cmp u_cmp (.i_a(w_ka), .i_b(w_kb), .o_before(w_before));

    // ranked priority encode: first covering mask in order
    always_comb begin
        w_lab = '0;
        w_hit = 1'b0;
        for (int k = 0; k < MAX_MASKS; k++) begin
            if (!w_hit && 5'(k) < w_n && i_coverage[r_ord[k]]) begin
                w_hit = 1'b1;
                w_lab = {1'b0, r_ord[k]} + 5'd1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc && i_kind == K_RESOLV) n_state = S_SORT;
                else if (w_acc && i_kind == K_REPORT) n_state = S_REPORT;
            end
            S_SORT: if (r_i >= w_n) n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            S_REPORT: begin
                if (!r_ov || i_ready) begin
                    if (r_rstat != ST_OK || w_n == 0 || r_rep + 5'd1 >= w_n)
                        n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_width <= '0; r_height <= '0; r_count <= '0;
            r_apix <= '0; r_rstat <= ST_OK; r_ov <= 1'b0;
            r_i <= '0; r_j <= '0; r_rep <= '0;
            for (int k = 0; k < MAX_MASKS; k++) begin
                r_area[k] <= '0; r_reg[k] <= '0; r_ord[k] <= IDX_W'(k);
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    CFG_COUNT:  r_count  <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (w_ov_set) r_ov <= 1'b1;
            else if (w_take) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: if (w_acc) begin
                    case (i_kind)
                        K_DESC: begin
                            r_man[i_mask_index]  <= i_manual_set;
                            r_pri[i_mask_index]  <= i_manual_priority;
                            r_stab[i_mask_index] <= i_stability_score;
                            r_iou[i_mask_index]  <= i_predicted_iou;
                        end
                        K_AREA: begin
                            for (int k = 0; k < MAX_MASKS; k++)
                                if (5'(k) < w_n && i_coverage[k])
                                    r_area[k] <= sat_inc(r_area[k]);
                            r_apix <= sat_inc(r_apix);
                        end
                        K_RESOLV: begin
                            if (r_width == 0 || r_height == 0) r_rstat <= ST_DIM;
                            else if (r_count == 0) r_rstat <= ST_NOMSK;
                            else if (r_apix != CNT_W'(r_width * r_height)
                                     || r_apix == CNT_MAX)
                                r_rstat <= ST_PIX;
                            else r_rstat <= ST_OK;
                            for (int k = 0; k < MAX_MASKS; k++)
                                r_ord[k] <= IDX_W'(k);
                            r_i <= 5'd1; r_j <= 5'd1;
                        end
                        K_LABEL: begin
                            r_opix <= '0; r_olast <= 1'b0;
                            r_ost <= r_rstat;
                            if (r_rstat == ST_OK && w_hit) begin
                                r_olab <= w_lab;
                                r_oidx <= 4'(w_lab - 5'd1);
                                r_reg[4'(w_lab - 5'd1)] <=
                                    sat_inc(r_reg[4'(w_lab - 5'd1)]);
                            end else begin
                                r_olab <= '0; r_oidx <= '0;
                            end
                        end
                        K_REPORT: r_rep <= '0;
                        default: ;
                    endcase
                end
                S_SORT: begin
                    if (r_i < w_n) begin
                        if (r_j != 0 && w_before) begin
                            r_ord[r_j[3:0]] <= r_ord[4'(r_j - 5'd1)];
                            r_ord[4'(r_j - 5'd1)] <= r_ord[r_j[3:0]];
                            r_j <= r_j - 5'd1;
                        end else begin
                            r_i <= r_i + 5'd1;
                            r_j <= r_i + 5'd1;
                        end
                    end
                end
                S_OUT: begin
                    // clear per-frame counters once the sort has used the areas
                    for (int k = 0; k < MAX_MASKS; k++) begin
                        r_area[k] <= '0; r_reg[k] <= '0;
                    end
                    r_apix <= '0;
                    r_olab <= '0; r_oidx <= '0; r_opix <= '0;
                    r_ost <= r_rstat; r_olast <= 1'b0;
                end
                S_REPORT: begin
                    if (!r_ov || i_ready) begin
                        r_olab <= '0;
                        if (r_rstat != ST_OK || w_n == 0) begin
                            r_oidx <= '0; r_opix <= '0; r_ost <= r_rstat;
                            r_olast <= 1'b1;
                        end else begin
                            r_oidx <= r_rep[3:0]; r_opix <= r_reg[r_rep[3:0]];
                            r_ost <= ST_OK; r_olast <= (r_rep + 5'd1 >= w_n);
                            r_rep <= r_rep + 5'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid         = r_ov;
    assign o_label         = r_olab;
    assign o_region_index  = r_oidx;
    assign o_region_pixels = r_opix;
    assign o_status        = r_ost;
    assign o_last          = r_olast;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("accept while busy");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_region_pixels)))
        else $error("result dropped");
    a_sort_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> o_valid) else $error("resolve result missing");
`endif
endmodule

### tb/sv/mask_priority_label_map_test.sv
module mask_priority_label_map_test;
    import mplm_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  midx;
        logic        man;
        logic [31:0] pri;
        logic [15:0] stab;
        logic [15:0] iou;
        logic [15:0] cov;
    } t_beat;

    typedef struct packed {
        logic [4:0]  label;
        logic [3:0]  region;
        logic [23:0] pixels;
        logic [1:0]  status;
        logic        last;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_WIDTH;
    logic [11:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_kind = K_DESC;
    logic [3:0]  i_mask_index = '0;
    logic        i_manual_set = 1'b0;
    logic signed [31:0] i_manual_priority = '0;
    logic [15:0] i_stability_score = '0;
    logic [15:0] i_predicted_iou = '0;
    logic [15:0] i_coverage = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [4:0]  o_label;
    logic [3:0]  o_region_index;
    logic [23:0] o_region_pixels;
    logic [1:0]  o_status;
    logic        o_last;

    mask_priority_label_map i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow copy of the block's state
    logic        sh_man   [MAX_MASKS];
    logic [31:0] sh_pri   [MAX_MASKS];
    logic [15:0] sh_stab  [MAX_MASKS];
    logic [15:0] sh_iou   [MAX_MASKS];
    logic [23:0] sh_area  [MAX_MASKS];
    logic [3:0]  sh_order [MAX_MASKS];
    logic [23:0] sh_region[MAX_MASKS];
    logic [23:0] sh_pix_cnt;
    logic [1:0]  sh_status;
    logic [11:0] sh_width, sh_height;
    logic [4:0]  sh_count;

    t_beat pending_beats[$];
    t_res  expected_results[$];
    int    mismatches = 0;
    int    cycle = 0;
    bit    hold_sender = 1'b0;
    bit    long_stall = 1'b0;
    bit    stim_done = 1'b0;

    task automatic queue_beat(t_beat b);
        pending_beats = {pending_beats, b};
    endtask

    task automatic expect_res(t_res r);
        expected_results = {expected_results, r};
    endtask

    function automatic logic [23:0] sat1(logic [23:0] v);
        return (v == CNT_MAX) ? v : v + 24'd1;
    endfunction

    function automatic int in_use();
        return (sh_count > MAX_MASKS) ? MAX_MASKS : int'(sh_count);
    endfunction

    function automatic bit outranks(int a, int b);
        if (sh_man[a] != sh_man[b]) return sh_man[a];
        if (sh_man[a]) begin
            if (sh_pri[a] != sh_pri[b]) return $signed(sh_pri[a]) < $signed(sh_pri[b]);
        end else begin
            if (sh_stab[a] != sh_stab[b]) return sh_stab[a] > sh_stab[b];
            if (sh_iou[a] != sh_iou[b]) return sh_iou[a] > sh_iou[b];
            if (sh_area[a] != sh_area[b]) return sh_area[a] > sh_area[b];
        end
        return a < b;
    endfunction

    // Advance the shadow state by one beat and queue what it should produce
    task automatic predict_labels(t_beat b);
        int n, j;
        logic [3:0] cur;
        t_res r;
        n = in_use();
        r = '0;
        case (b.kind)
            K_DESC: begin
                sh_man[b.midx] = b.man; sh_pri[b.midx] = b.pri;
                sh_stab[b.midx] = b.stab; sh_iou[b.midx] = b.iou;
            end
            K_AREA: begin
                for (int i = 0; i < n; i++)
                    if (b.cov[i]) sh_area[i] = sat1(sh_area[i]);
                sh_pix_cnt = sat1(sh_pix_cnt);
            end
            K_RESOLV: begin
                if (sh_width == 0 || sh_height == 0) sh_status = ST_DIM;
                else if (sh_count == 0) sh_status = ST_NOMSK;
                else if (32'(sh_pix_cnt) != 32'(sh_width) * 32'(sh_height))
                    sh_status = ST_PIX;
                else sh_status = ST_OK;
                for (int i = 0; i < MAX_MASKS; i++) sh_order[i] = 4'(i);
                for (int i = 1; i < n; i++) begin
                    cur = sh_order[i];
                    j = i;
                    while (j > 0 && outranks(cur, sh_order[j-1])) begin
                        sh_order[j] = sh_order[j-1];
                        j--;
                    end
                    sh_order[j] = cur;
                end
                for (int i = 0; i < MAX_MASKS; i++) begin
                    sh_region[i] = '0; sh_area[i] = '0;
                end
                sh_pix_cnt = '0;
                r.status = sh_status;
                expect_res(r);
            end
            K_LABEL: begin
                if (sh_status == ST_OK)
                    for (int i = 0; i < n; i++)
                        if (b.cov[sh_order[i]]) begin
                            r.label = 5'(sh_order[i]) + 5'd1;
                            r.region = sh_order[i];
                            sh_region[sh_order[i]] = sat1(sh_region[sh_order[i]]);
                            break;
                        end
                r.status = sh_status;
                expect_res(r);
            end
            K_REPORT: begin
                if (sh_status != ST_OK || n == 0) begin
                    r.status = sh_status; r.last = 1'b1;
                    expect_res(r);
                end else
                    for (int i = 0; i < n; i++) begin
                        r = '0;
                        r.region = 4'(i); r.pixels = sh_region[i];
                        r.last = (i == n - 1);
                        expect_res(r);
                    end
            end
            default: ;
        endcase
    endtask

    // Driver: bursts of beats with random gaps; hold valid until accepted
    int gap = 0;
    int burst = 0;
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (i_rst_n) begin
            if (i_valid && o_ready) predict_labels(pending_beats.pop_front());
            if (!(i_valid && !o_ready)) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_beats.size() > 0 && !hold_sender) begin
                    t_beat nb;
                    nb = pending_beats[0];
                    i_valid <= 1'b1;
                    i_kind <= nb.kind; i_mask_index <= nb.midx;
                    i_manual_set <= nb.man; i_manual_priority <= nb.pri;
                    i_stability_score <= nb.stab; i_predicted_iou <= nb.iou;
                    i_coverage <= nb.cov;
                    if (burst > 0) burst <= burst - 1;
                    else begin
                        burst <= $urandom_range(0, 20);
                        gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else i_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                t_res got, exp_r;
                got = {o_label, o_region_index, o_region_pixels, o_status, o_last};
                if (expected_results.size() == 0) begin
                    if (mismatches < 10) $display("unexpected result beat %h", got);
                    mismatches = mismatches + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        if (mismatches < 10)
                            $display({"mismatch: exp lbl=%0d reg=%0d pix=%0d st=%0d",
                                      " last=%0d got lbl=%0d reg=%0d pix=%0d st=%0d",
                                      " last=%0d"},
                                exp_r.label, exp_r.region, exp_r.pixels, exp_r.status,
                                exp_r.last, got.label, got.region, got.pixels, got.status,
                                got.last);
                        mismatches = mismatches + 1;
                    end
                end
            end
            i_ready <= long_stall ? 1'b0 : ($urandom_range(0, 3) != 0 || cycle[9]);
        end
    end

    // Hold the receiver off for a long stretch while the sender has work queued
    initial begin
        int wait_cyc;
        forever begin
            repeat ($urandom_range(300, 1500)) @(posedge i_clk);
            while (pending_beats.size() < 8) @(posedge i_clk);
            long_stall <= 1'b1;
            wait_cyc = 0;
            while (wait_cyc < 200) begin
                @(posedge i_clk);
                wait_cyc++;
            end
            long_stall <= 1'b0;
        end
    end

    // Timeout
    always @(posedge i_clk)
        if (cycle > 1000000) begin
            $display("mask_priority_label_map test failed");
            $finish;
        end

    function automatic t_beat mk(logic [2:0] k, logic [15:0] cov);
        t_beat b;
        b = '0; b.kind = k; b.cov = cov;
        return b;
    endfunction

    task automatic add_desc(int m, bit man, logic [31:0] pri, logic [15:0] st,
                            logic [15:0] io);
        t_beat b;
        b = mk(K_DESC, 16'($urandom()));
        b.midx = 4'(m); b.man = man; b.pri = pri; b.stab = st; b.iou = io;
        queue_beat(b);
    endtask

    // Drain: wait till nothing is queued or expected, plus block latency
    task automatic drain();
        while (pending_beats.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [11:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH:  sh_width = v;
            CFG_HEIGHT: sh_height = v;
            default:    sh_count = v[4:0];
        endcase
    endtask

    // One frame: descriptors, maybe a bad kind, area pass, resolve, labels, report
    task automatic frame(int w, int h, int n, int pix_err, int tie);
        int npix;
        logic [15:0] cov;
        write_cfg(CFG_WIDTH, 12'(w));
        write_cfg(CFG_HEIGHT, 12'(h));
        write_cfg(CFG_COUNT, 12'(n));
        for (int m = 0; m < MAX_MASKS; m++)
            if (tie) add_desc(m, m[0], 32'h8000_0000, 16'hffff, 16'h0);
            else add_desc(m, $urandom_range(0, 2) == 0, $urandom(),
                          16'($urandom_range(0, 3) << 14), 16'($urandom_range(0, 3)));
        if ($urandom_range(0, 5) == 0)
            queue_beat(mk(3'd5 + 3'($urandom_range(0, 2)), '0));
        npix = w * h + pix_err;
        for (int p = 0; p < npix; p++) queue_beat(mk(K_AREA, 16'($urandom())));
        queue_beat(mk(K_RESOLV, '0));
        for (int p = 0; p < w * h; p++) begin
            cov = 16'($urandom());
            if ($urandom_range(0, 7) == 0) cov = '0;
            queue_beat(mk(K_LABEL, cov));
        end
        queue_beat(mk(K_REPORT, '0));
        drain();
    endtask

    initial begin
        for (int i = 0; i < MAX_MASKS; i++) begin
            sh_man[i] = 0; sh_pri[i] = 0; sh_stab[i] = 0; sh_iou[i] = 0;
            sh_area[i] = 0; sh_order[i] = 4'(i); sh_region[i] = 0;
        end
        sh_pix_cnt = 0; sh_status = ST_OK;
        sh_width = 0; sh_height = 0; sh_count = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: bad dimensions, no masks, extreme fields, ties, mismatch
        for (int m = 0; m < MAX_MASKS; m++)
            add_desc(m, m < 2, m ? 32'h7fff_ffff : 32'h8000_0000, 16'hffff, 16'hffff);
        queue_beat(mk(K_RESOLV, '0));
        queue_beat(mk(K_LABEL, 16'hffff));
        queue_beat(mk(K_REPORT, '0));
        drain();
        frame(1, 1, 0, 0, 0);
        frame(2, 2, 16, 0, 1);
        frame(3, 1, 31, 1, 0);
        frame(1, 2, 1, 0, 0);

        // Sender pause until everything has come, then a wide frame
        hold_sender = 1'b1;
        drain();
        hold_sender = 1'b0;
        write_cfg(CFG_WIDTH, 12'hfff);
        write_cfg(CFG_HEIGHT, 12'hfff);
        queue_beat(mk(K_RESOLV, '0));
        queue_beat(mk(K_REPORT, '0));
        drain();

        // Random frames
        for (int f = 0; f < 7; f++)
            frame($urandom_range(1, 5), $urandom_range(1, 4), $urandom_range(1, 16),
                  ($urandom_range(0, 4) == 0) ? 1 : 0, $urandom_range(0, 5) == 0);

        drain();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("mask_priority_label_map test passed");
        else
            $display("mask_priority_label_map test failed");
        $finish;
    end
endmodule

### files.f
sv/mplm_pkg.sv
sv/mplm_cmp.sv
sv/mask_priority_label_map.sv
tb/sv/mask_priority_label_map_test.sv
